FILE: rtl/core/ufold_pkg.sv
// Shared types, constants and folding functions for the UTF-8 search folding block.
package ufold_pkg;

    // Code point width: a four-byte lead carries three bits, so 21 bits in all.
    localparam int UF_CP_W   = 21;
    // Most code points that one input byte can release in a single transfer.
    localparam int UF_SLOTS  = 4;
    // Default depth of the queue between the front and back ends.
    localparam int UF_QDEPTH = 2;

    localparam logic [UF_CP_W-1:0] UF_MAX_CP = 21'h10FFFF;

    // Encoded length codes, stored as length minus one.
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } t_len;

    // One input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_item;
        logic       end_of_string;
    } t_out_item;

    // Work for one input byte: folded code points in order, with keep bits.
    typedef struct packed {
        logic [UF_SLOTS-1:0][UF_CP_W-1:0] cp;
        t_len [UF_SLOTS-1:0]              len;
        logic [UF_SLOTS-1:0]              keep;
        logic                             eos;
    } t_pkt;

    // Continuation bytes that a lead byte asks for; zero when it is no lead.
    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b[7:5] == 3'b110) begin
            n = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            n = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Code points that vanish from the output: zero, combining marks and
    // anything beyond the Unicode range.
    function automatic logic cp_dropped(input logic [UF_CP_W-1:0] cp);
        logic d;
        d = (cp == '0)
            || (cp >= 21'h000300 && cp <= 21'h00036F)
            || (cp >= 21'h001AB0 && cp <= 21'h001AFF)
            || (cp >= 21'h001DC0 && cp <= 21'h001DFF)
            || (cp >= 21'h0020D0 && cp <= 21'h0020FF)
            || (cp >= 21'h00FE20 && cp <= 21'h00FE2F)
            || (cp > UF_MAX_CP);
        return d;
    endfunction

    // Latin-1 accented letters to their base letter, ASCII capitals to lower case.
    function automatic logic [UF_CP_W-1:0] fold_cp(input logic [UF_CP_W-1:0] cp);
        logic [UF_CP_W-1:0] r;
        r = cp;
        if (cp[UF_CP_W-1:8] == '0) begin
            case (cp[7:0]) inside
                [8'hC0:8'hC6], [8'hE0:8'hE5]: r = 21'h61;
                8'hC7, 8'hE7:                 r = 21'h63;
                [8'hC8:8'hCB], [8'hE8:8'hEB]: r = 21'h65;
                [8'hCC:8'hCF], [8'hEC:8'hEF]: r = 21'h69;
                8'hD1, 8'hF1:                 r = 21'h6E;
                [8'hD2:8'hD6], [8'hF2:8'hF6]: r = 21'h6F;
                [8'hD9:8'hDC], [8'hF9:8'hFC]: r = 21'h75;
                8'hDD, 8'hFD, 8'hFF:          r = 21'h79;
                [8'h41:8'h5A]:                r = cp + 21'h20;
                default:                      r = cp;
            endcase
        end
        return r;
    endfunction

    // Number of UTF-8 bytes needed for a code point.
    function automatic t_len enc_len(input logic [UF_CP_W-1:0] cp);
        t_len l;
        if (cp <= 21'h00007F) begin
            l = LEN_1;
        end else if (cp <= 21'h0007FF) begin
            l = LEN_2;
        end else if (cp <= 21'h00FFFF) begin
            l = LEN_3;
        end else begin
            l = LEN_4;
        end
        return l;
    endfunction

    // Byte number idx of the UTF-8 form of a code point.
    function automatic logic [7:0] enc_byte(input logic [UF_CP_W-1:0] cp,
                                            input t_len len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            LEN_1: b = {1'b0, cp[6:0]};
            LEN_2: begin
                case (idx)
                    2'd0:    b = {3'b110, cp[10:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_4: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/ufold_fifo.sv
// Short queue of decoded work between the front and back ends.
module ufold_fifo #(
    parameter int DEPTH = ufold_pkg::UF_QDEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    input  ufold_pkg::t_pkt i_wr_data,
    output logic            o_wr_ready,
    output logic            o_rd_valid,
    output ufold_pkg::t_pkt o_rd_data,
    input  logic            i_rd_ready
);
    import ufold_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            wr_fire;
    logic            rd_fire;

    // Handshake on both sides.
    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rd];
    assign wr_fire    = i_wr_valid && o_wr_ready;
    assign rd_fire    = o_rd_valid && i_rd_ready;

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_fire) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_fire) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

endmodule

FILE: rtl/core/ufold_front.sv
// Front end: accepts text bytes, decodes UTF-8 and classifies the code points released.
module ufold_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ufold_pkg::t_in_item i_in_item,
    output logic                o_in_ready,
    output logic                o_pkt_valid,
    output ufold_pkg::t_pkt     o_pkt,
    input  logic                i_pkt_ready
);
    import ufold_pkg::*;

    logic [7:0]          r_lead, n_lead;
    logic [7:0]          r_cont [2];
    logic [1:0]          r_count, n_count;
    logic                cont_we;
    logic                cont_idx;

    logic                fire;
    logic [7:0]          b;
    logic                last;
    logic                is_cont;
    logic                is_lead;
    logic [1:0]          need;
    logic                fresh_path;
    logic                complete;
    logic                flush_pre;
    logic                keep_b;
    logic [UF_CP_W-1:0]  full_cp;
    logic [7:0]          held [4];
    logic [7:0]          raw;
    logic [UF_CP_W-1:0]  slot_cp;
    logic                slot_keep;
    logic [UF_CP_W-1:0]  folded;
    t_pkt                pkt;

    assign fire       = i_in_valid && o_in_ready;
    assign o_in_ready = i_pkt_ready;
    assign b          = i_in_item.in_byte;
    assign last       = i_in_item.string_last;
    assign is_cont    = (b[7:6] == 2'b10);
    assign is_lead    = (lead_need(b) != 2'd0);
    assign need       = lead_need(r_lead);

    // Held bytes in arrival order; the fourth place is never a held byte.
    assign held[0] = r_lead;
    assign held[1] = r_cont[0];
    assign held[2] = r_cont[1];
    assign held[3] = 8'h00;

    // Classify the byte against the held sequence and work out the next state.
    always_comb begin
        fresh_path = (r_count == 2'd0) || !is_cont;
        complete   = !fresh_path && (r_count >= need);
        flush_pre  = 1'b0;
        keep_b     = 1'b0;
        n_lead     = r_lead;
        n_count    = r_count;
        cont_we    = 1'b0;
        cont_idx   = r_count[1];
        if (fresh_path) begin
            // Bad continuation (or nothing held): release all held bytes raw,
            // then take the byte from the empty state.
            flush_pre = (r_count != 2'd0);
            keep_b    = !is_lead || last;
            if (is_lead) begin
                n_lead = b;
            end
            n_count = (is_lead && !last) ? 2'd1 : 2'd0;
        end else if (complete) begin
            n_count = 2'd0;
        end else begin
            // Store the continuation; the end of the text flushes everything.
            cont_we   = 1'b1;
            flush_pre = last;
            keep_b    = last;
            n_count   = last ? 2'd0 : r_count + 2'd1;
        end
    end

    // Code point of a complete sequence.
    always_comb begin
        unique case (need)
            2'd1:    full_cp = {10'd0, r_lead[4:0], b[5:0]};
            2'd2:    full_cp = {5'd0, r_lead[3:0], r_cont[0][5:0], b[5:0]};
            default: full_cp = {r_lead[2:0], r_cont[0][5:0], r_cont[1][5:0], b[5:0]};
        endcase
    end

    // Lay the released code points out in slots, then drop, fold and size them.
    always_comb begin
        pkt     = '0;
        pkt.eos = last;
        for (int j = 0; j < UF_SLOTS; j++) begin
            raw       = (2'(j) == r_count) ? b : held[j];
            slot_cp   = {13'd0, raw};
            slot_keep = (2'(j) < r_count) ? flush_pre : ((2'(j) == r_count) && keep_b);
            if (complete) begin
                slot_cp   = full_cp;
                slot_keep = (j == 0);
            end
            folded      = fold_cp(slot_cp);
            pkt.cp[j]   = folded;
            pkt.len[j]  = enc_len(folded);
            pkt.keep[j] = slot_keep && !cp_dropped(slot_cp);
        end
    end

    // Only bytes that release output, or end the text, produce work.
    assign o_pkt_valid = i_in_valid && ((pkt.keep != '0) || last);
    assign o_pkt       = pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= 8'h00;
            r_count <= 2'd0;
        end else if (fire) begin
            r_lead  <= n_lead;
            r_count <= n_count;
        end
    end

    // Continuation store: written before it is read, so no reset.
    always_ff @(posedge i_clk) begin
        if (fire && cont_we) begin
            r_cont[cont_idx] <= b;
        end
    end

`ifndef SYNTHESIS
    // The end of the text always leaves the decoder empty.
    a_end_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && last) |=> (r_count == 2'd0))
        else $error("held bytes survive the end of the text");

    // Two held bytes only under a lead that wants at least two continuations.
    a_two_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> (r_lead[7:4] == 4'b1110 || r_lead[7:3] == 5'b11110))
        else $error("two bytes held under a short lead");

    // Three held bytes only under a four-byte lead.
    a_three_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd3) |-> (r_lead[7:3] == 5'b11110))
        else $error("three bytes held under a lead that needs fewer");
`endif

endmodule

FILE: rtl/core/ufold_back.sv
// Back end: encodes queued code points as UTF-8 and sends them out one byte a transfer.
module ufold_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pkt_valid,
    input  ufold_pkg::t_pkt      i_pkt,
    output logic                 o_pkt_ready,
    output logic                 o_out_valid,
    output ufold_pkg::t_out_item o_out_item,
    input  logic                 i_out_ready
);
    import ufold_pkg::*;

    logic [UF_SLOTS-1:0] r_done;
    logic [1:0]          r_bidx;
    logic                r_ovalid;
    t_out_item           r_out;

    logic [UF_SLOTS-1:0] remaining;
    logic [UF_SLOTS-1:0] cur_oh;
    logic [UF_SLOTS-1:0] rest;
    logic [1:0]          cur;
    logic                none_left;
    t_len                cur_len;
    logic                cp_done;
    logic                item_done;
    logic                load;
    t_out_item           nxt;

    // Pick the first code point of the head packet not yet sent.
    assign remaining = i_pkt.keep & ~r_done;
    assign none_left = (remaining == '0);

    always_comb begin
        cur = 2'd0;
        for (int j = UF_SLOTS - 1; j >= 0; j--) begin
            if (remaining[j]) begin
                cur = 2'(j);
            end
        end
    end

    assign cur_oh    = UF_SLOTS'(1) << cur;
    assign rest      = remaining & ~cur_oh;
    assign cur_len   = i_pkt.len[cur];
    assign cp_done   = (r_bidx == cur_len);
    assign item_done = none_left || (cp_done && (rest == '0));

    // Next result: a bare end marker when the packet carries no code point.
    always_comb begin
        nxt.out_byte      = none_left ? 8'h00 : enc_byte(i_pkt.cp[cur], cur_len, r_bidx);
        nxt.byte_valid    = !none_left;
        nxt.last_of_item  = item_done;
        nxt.end_of_string = item_done && i_pkt.eos;
    end

    // The output register loads from a queued packet when it is empty or being drained.
    assign load        = i_pkt_valid && (!r_ovalid || i_out_ready);
    assign o_pkt_ready = load && item_done;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= '0;
            r_bidx   <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                if (item_done) begin
                    r_done <= '0;
                    r_bidx <= 2'd0;
                end else if (cp_done) begin
                    r_done <= r_done | cur_oh;
                    r_bidx <= 2'd0;
                end else begin
                    r_bidx <= r_bidx + 2'd1;
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= nxt;
        end
    end

`ifndef SYNTHESIS
    // A packet with nothing to send must be the end of the text.
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pkt_valid && none_left) |-> i_pkt.eos)
        else $error("empty packet that does not end the text");

    // The byte counter never runs past the length of the code point in hand.
    a_bidx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pkt_valid && !none_left) |-> (r_bidx <= cur_len))
        else $error("byte index beyond encoded length");

    // A result without a byte is always the closing result of the text.
    a_marker_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_out.byte_valid) |-> (r_out.last_of_item && r_out.end_of_string))
        else $error("byteless result that does not close the text");
`endif

endmodule

FILE: rtl/core/utf8_search_fold_top.sv
// Top level of the UTF-8 search folding block: front end, queue and back end.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_ready   | i_in_item  (byte, end mark)
//   out     | output    | o_out_valid / i_out_ready | o_out_item (byte and flags)
//
// Each cycle the front end takes one byte unless the queue is full, and the back end
// sends one byte unless it has nothing queued or the receiver is not ready. A byte
// yields up to eight output bytes, and a silent last byte yields a bare end marker.
// The queue of QDEPTH packets lets the front end keep taking bytes; a full queue stalls it.
// Reset is synchronous and active low; it empties the queue and the decoder.
// The first result of a byte passes through the queue and then the output register.
module utf8_search_fold_top #(
    parameter int QDEPTH = ufold_pkg::UF_QDEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ufold_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ufold_pkg::t_out_item o_out_item
);
    import ufold_pkg::*;

    logic fr_valid;
    logic fr_ready;
    t_pkt fr_pkt;
    logic bk_valid;
    logic bk_ready;
    t_pkt bk_pkt;

    // Decoder and classifier.
    ufold_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_ready  (o_in_ready),
        .o_pkt_valid (fr_valid),
        .o_pkt       (fr_pkt),
        .i_pkt_ready (fr_ready)
    );

    // Queue between the two halves.
    ufold_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fr_valid),
        .i_wr_data  (fr_pkt),
        .o_wr_ready (fr_ready),
        .o_rd_valid (bk_valid),
        .o_rd_data  (bk_pkt),
        .i_rd_ready (bk_ready)
    );

    // Encoder and output register.
    ufold_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (bk_valid),
        .i_pkt       (bk_pkt),
        .o_pkt_ready (bk_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready)
    );

endmodule

FILE: verif/ufold_check_pkg.sv
// Scoreboard class that predicts and checks the folded UTF-8 byte stream.
`timescale 1ns / 100ps

package ufold_check_pkg;

    import ufold_pkg::*;

    class fold_checker;

        // Decoder state: the held lead byte, up to two continuations and the count.
        logic [7:0]  lead_byte;
        logic [7:0]  cont_bytes [2];
        int unsigned held;

        // Bytes produced by the current input byte, and results still awaited.
        logic [7:0]  step_bytes [$];
        t_out_item   expected_bytes [$];

        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned strings_seen;
        int unsigned markers_seen;

        function new();
            lead_byte     = 8'h00;
            cont_bytes[0] = 8'h00;
            cont_bytes[1] = 8'h00;
            held          = 0;
            mismatches    = 0;
            results_seen  = 0;
            strings_seen  = 0;
            markers_seen  = 0;
        endfunction

        // Zero, the combining mark ranges and anything beyond Unicode vanish.
        function bit vanishes(int unsigned cp);
            return (cp == 0)
                || (cp >= 'h300  && cp <= 'h36F)
                || (cp >= 'h1AB0 && cp <= 'h1AFF)
                || (cp >= 'h1DC0 && cp <= 'h1DFF)
                || (cp >= 'h20D0 && cp <= 'h20FF)
                || (cp >= 'hFE20 && cp <= 'hFE2F)
                || (cp > UF_MAX_CP);
        endfunction

        // Accented Latin-1 letters map to their base letter; capitals to lower case.
        function int unsigned base_letter(int unsigned cp);
            if ((cp >= 'hC0 && cp <= 'hC6) || (cp >= 'hE0 && cp <= 'hE5)) return 'h61;
            if (cp == 'hC7 || cp == 'hE7) return 'h63;
            if ((cp >= 'hC8 && cp <= 'hCB) || (cp >= 'hE8 && cp <= 'hEB)) return 'h65;
            if ((cp >= 'hCC && cp <= 'hCF) || (cp >= 'hEC && cp <= 'hEF)) return 'h69;
            if (cp == 'hD1 || cp == 'hF1) return 'h6E;
            if ((cp >= 'hD2 && cp <= 'hD6) || (cp >= 'hF2 && cp <= 'hF6)) return 'h6F;
            if ((cp >= 'hD9 && cp <= 'hDC) || (cp >= 'hF9 && cp <= 'hFC)) return 'h75;
            if (cp == 'hDD || cp == 'hFD || cp == 'hFF) return 'h79;
            if (cp >= 'h41 && cp <= 'h5A) return cp + 'h20;
            return cp;
        endfunction

        function void put8(int unsigned v);
            step_bytes.insert(step_bytes.size(), v[7:0]);
        endfunction

        // Fold one code point and append its UTF-8 form to this step's bytes.
        function void put_cp(int unsigned cp);
            int unsigned f;
            if (vanishes(cp)) return;
            f = base_letter(cp);
            if (f <= 'h7F) begin
                put8(f);
            end else if (f <= 'h7FF) begin
                put8('hC0 | (f >> 6));
                put8('h80 | (f & 'h3F));
            end else if (f <= 'hFFFF) begin
                put8('hE0 | (f >> 12));
                put8('h80 | ((f >> 6) & 'h3F));
                put8('h80 | (f & 'h3F));
            end else begin
                put8('hF0 | (f >> 18));
                put8('h80 | ((f >> 12) & 'h3F));
                put8('h80 | ((f >> 6) & 'h3F));
                put8('h80 | (f & 'h3F));
            end
        endfunction

        // Continuation bytes that a lead byte calls for; zero for anything else.
        function int unsigned conts_for(logic [7:0] b);
            if (b[7:5] == 3'b110)   return 1;
            if (b[7:4] == 4'b1110)  return 2;
            if (b[7:3] == 5'b11110) return 3;
            return 0;
        endfunction

        // Every held byte goes out as a raw code point, oldest first.
        function void release_held();
            if (held == 0) return;
            put_cp(lead_byte);
            for (int k = 0; k + 1 < held && k < 2; k++) put_cp(cont_bytes[k]);
            held = 0;
        endfunction

        function void start_fresh(logic [7:0] b);
            if (b < 8'h80) begin
                put_cp(b);
            end else if (conts_for(b) != 0) begin
                lead_byte = b;
                held      = 1;
            end else begin
                put_cp(b);
            end
        endfunction

        function void absorb(logic [7:0] b);
            int unsigned need;
            int unsigned got;
            int unsigned cp;
            if (held == 0) begin
                start_fresh(b);
                return;
            end
            // A byte that is no continuation breaks the sequence and is taken again.
            if (b[7:6] != 2'b10) begin
                release_held();
                start_fresh(b);
                return;
            end
            need = conts_for(lead_byte);
            got  = held - 1;
            if (got + 1 >= need || got >= 2) begin
                case (need)
                    1: cp = {lead_byte[4:0], b[5:0]};
                    2: cp = {lead_byte[3:0], cont_bytes[0][5:0], b[5:0]};
                    default: cp = {lead_byte[2:0], cont_bytes[0][5:0],
                                   cont_bytes[1][5:0], b[5:0]};
                endcase
                held = 0;
                put_cp(cp);
            end else begin
                cont_bytes[got] = b;
                held++;
            end
        endfunction

        // Predict the results of one accepted input transfer.
        function void note_input(t_in_item it);
            t_out_item r;
            int        n;
            step_bytes.delete();
            absorb(it.in_byte);
            if (it.string_last) begin
                release_held();
                strings_seen++;
            end
            n = step_bytes.size();
            if (n == 0) begin
                // A silent byte ending the text still yields a bare end marker.
                if (it.string_last) begin
                    r.out_byte      = 8'h00;
                    r.byte_valid    = 1'b0;
                    r.last_of_item  = 1'b1;
                    r.end_of_string = 1'b1;
                    expected_bytes.insert(expected_bytes.size(), r);
                    markers_seen++;
                end
                return;
            end
            for (int k = 0; k < n; k++) begin
                r.out_byte      = step_bytes[k];
                r.byte_valid    = 1'b1;
                r.last_of_item  = (k == n - 1);
                r.end_of_string = (k == n - 1) && it.string_last;
                expected_bytes.insert(expected_bytes.size(), r);
            end
        endfunction

        // Compare one output transfer with the oldest prediction.
        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected_bytes.size() == 0) begin
                if (mismatches < 10)
                    $display("Unexpected output: byte %02h valid %b last %b end %b",
                             got.out_byte, got.byte_valid, got.last_of_item,
                             got.end_of_string);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid
                || got.last_of_item !== want.last_of_item
                || got.end_of_string !== want.end_of_string) begin
                if (mismatches < 10)
                    $display("Mismatch at output %0d: ", results_seen,
                             "expected byte %02h valid %b last %b end %b, ",
                             want.out_byte, want.byte_valid,
                             want.last_of_item, want.end_of_string,
                             "got byte %02h valid %b last %b end %b",
                             got.out_byte, got.byte_valid, got.last_of_item,
                             got.end_of_string);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Predictions never matched count as failures too.
        function int unsigned closing_errors();
            if (expected_bytes.size() != 0) begin
                $display("%0d expected output bytes never arrived", expected_bytes.size());
                mismatches += expected_bytes.size();
            end
            return mismatches;
        endfunction

    endclass

endpackage

FILE: verif/utf8_search_fold_top_tb.sv
// Self-checking testbench for the UTF-8 search folding block.
`timescale 1ns / 100ps

module utf8_search_fold_top_tb;

    import ufold_pkg::*;
    import ufold_check_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 80;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    fold_checker fold_sb = new();

    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned out_count = 0;
    int          rx_stall = 0;
    bit          rx_took = 1'b0;
    bit          rx_calm = 1'b0;
    bit          hold_out = 1'b0;

    logic [7:0]  text_bytes [$];

    // Directed opening text: {end mark, byte}.
    logic [8:0] opening_text [0:26] = '{
        9'h041, 9'h05A, 9'h000, 9'h07F,          // capitals, zero, top of ASCII
        9'h0C3, 9'h080, 9'h0C3, 9'h0BF,          // U+00C0 and U+00FF fold to a, y
        9'h0CC, 9'h080,                          // first combining mark, dropped
        9'h0E2, 9'h083, 9'h0BF,                  // U+20FF, dropped
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,          // U+10FFFF, kept
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,          // beyond Unicode, dropped
        9'h0E2, 9'h041,                          // bad continuation
        9'h0FF,                                  // raw byte
        9'h0F0, 9'h19F,                          // sequence cut short by the end
        9'h100                                   // silent byte that ends the text
    };

    // Edges of the combining mark ranges.
    int unsigned mark_edges [0:9] = '{
        'h300, 'h36F, 'h1AB0, 'h1AFF, 'h1DC0, 'h1DFF, 'h20D0, 'h20FF, 'hFE20, 'hFE2F
    };

    utf8_search_fold_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run exceeded %0d cycles", CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check every output transfer and switch the receiver's mood now and then.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            fold_sb.check_result(out_item);
            rx_took = 1'b1;
            out_count++;
            if (out_count % 37 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Receiver: a random stall after each transfer, plus one long hold-off on request.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out = 1'b0;
                rx_stall = 0;
            end
            if (rx_took) begin
                rx_took  = 1'b0;
                rx_stall = rx_calm ? 0 : $urandom_range(0, 6);
            end
            if (rx_stall > 0) begin
                out_ready = 1'b0;
                rx_stall--;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    // Offer one byte after a gap and wait for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
        t_in_item it;
        it.in_byte     = b;
        it.string_last = last;
        repeat (gap) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        fold_sb.note_input(it);
        items_sent++;
    endtask

    // Append one byte to the text under construction.
    function automatic void add_text_byte(input logic [7:0] v);
        text_bytes.insert(text_bytes.size(), v);
    endfunction

    // Append the UTF-8 form of a code point up to 21 bits; returns its length.
    function automatic int append_utf8(int unsigned cp);
        if (cp <= 'h7F) begin
            add_text_byte(cp[7:0]);
            return 1;
        end
        if (cp <= 'h7FF) begin
            add_text_byte(8'hC0 | cp[10:6]);
            add_text_byte(8'h80 | cp[5:0]);
            return 2;
        end
        if (cp <= 'hFFFF) begin
            add_text_byte(8'hE0 | cp[15:12]);
            add_text_byte(8'h80 | cp[11:6]);
            add_text_byte(8'h80 | cp[5:0]);
            return 3;
        end
        add_text_byte(8'hF0 | cp[20:18]);
        add_text_byte(8'h80 | cp[17:12]);
        add_text_byte(8'h80 | cp[11:6]);
        add_text_byte(8'h80 | cp[5:0]);
        return 4;
    endfunction

    // Code point drawn from the classes the block treats differently.
    function automatic int unsigned pick_cp();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 'h7F);
            2, 3:    return $urandom_range('h80, 'hFF);
            4:       return mark_edges[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
            5:       return $urandom_range('h100, 'h7FF);
            6:       return $urandom_range('h800, 'hFFFF);
            7:       return $urandom_range('h10000, 'h10FFFF);
            8:       return $urandom_range('h110000, 'h1FFFFF);
            default: return $urandom_range('h41, 'h5A);
        endcase
    endfunction

    // Build one text of mostly well-formed sequences with some noise, then send it.
    task automatic send_random_text(input int n_cps, input bit calm);
        int len;
        int cut;
        text_bytes.delete();
        for (int k = 0; k < n_cps; k++) begin
            case ($urandom_range(0, 15))
                11, 12: add_text_byte(8'($urandom_range(0, 255)));
                13: begin
                    add_text_byte(8'hC0);
                    add_text_byte(8'h80);
                end
                14, 15: begin
                    // Multi-byte sequence cut short, sometimes followed by a breaking byte.
                    len = append_utf8($urandom_range('h80, 'h1FFFFF));
                    cut = $urandom_range(1, len - 1);
                    repeat (cut) void'(text_bytes.pop_back());
                    if ($urandom_range(0, 1))
                        add_text_byte(8'($urandom_range(0, 1) ?
                                         $urandom_range(0, 'h7F) :
                                         $urandom_range('hC0, 'hFF)));
                end
                default: void'(append_utf8(pick_cp()));
            endcase
        end
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1,
                      calm ? 0 : $urandom_range(0, 6));
    endtask

    // Main sequence: reset, directed text, random texts, pressure, drain.
    initial begin
        int unsigned errors;
        bit          hold_done;
        bit          pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (opening_text[i])
            send_byte(opening_text[i][7:0], opening_text[i][8], $urandom_range(0, 6));

        while (items_sent < RANDOM_ITEMS + 27) begin
            if (!hold_done && items_sent >= 150) begin
                // Long receiver hold-off while the sender keeps pushing.
                hold_done = 1'b1;
                hold_out  = 1'b1;
                send_random_text(24, 1'b1);
            end else if (!pause_done && items_sent >= 280) begin
                // Sender pause until the block has delivered everything.
                pause_done = 1'b1;
                @(negedge i_clk);
                in_valid = 1'b0;
                while (fold_sb.pending() != 0) @(posedge i_clk);
            end else begin
                send_random_text($urandom_range(1, 10), $urandom_range(0, 4) == 0);
            end
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        while (fold_sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        errors = fold_sb.closing_errors();
        $display("Sent %0d text bytes in %0d texts; ", items_sent, fold_sb.strings_seen,
                 "checked %0d output transfers, %0d of them bare end markers.",
                 fold_sb.results_seen, fold_sb.markers_seen);
        $display("Included a %0d-cycle receiver hold-off and a full drain pause; %0d errors.",
                 HOLD_CYCLES, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ufold_pkg.sv
rtl/core/ufold_fifo.sv
rtl/core/ufold_front.sv
rtl/core/ufold_back.sv
rtl/core/utf8_search_fold_top.sv
verif/ufold_check_pkg.sv
verif/utf8_search_fold_top_tb.sv
